// File: src/prre_pkg.sv
// Shared types, widths and constants of the pixel row run extractor.
package prre_pkg;

  localparam int unsigned PIX_W       = 24;
  localparam int unsigned COORD_W     = 20;
  localparam int unsigned CFG_DIM_W   = 13;
  localparam int unsigned CFG_SCALE_W = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned MAX_SCALE_DEF = 255;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIRROR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIRROR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NEGATIVE = 3'd5;

  localparam logic [CFG_DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [CFG_SCALE_W-1:0] SCALE_RST  = 8'd1;

  localparam logic [PIX_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [PIX_W-1:0] COLOR_WHITE = 24'hffffff;

  // Effective settings after clamping, as seen by the run logic.
  typedef struct packed {
    logic [CFG_DIM_W-1:0]   width;
    logic [CFG_DIM_W-1:0]   height;
    logic [CFG_SCALE_W-1:0] scale;
    logic                   mirror_x;
    logic                   mirror_y;
    logic                   negative;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x_end;
  } seg_t;

endpackage

// File: src/prre_cfg_regs.sv
// Configuration registers of the run extractor with dimension and scale clamping.
module prre_cfg_regs #(
  parameter int unsigned MAX_DIM   = prre_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_SCALE = prre_pkg::MAX_SCALE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prre_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [prre_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output prre_pkg::cfg_t                      cfg_o
);
  import prre_pkg::*;

  logic [CFG_DIM_W-1:0]   width_q, height_q;
  logic [CFG_SCALE_W-1:0] scale_q;
  logic                   mirror_x_q, mirror_y_q, negative_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      scale_q    <= SCALE_RST;
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      negative_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:    width_q    <= cfg_wdata_i[CFG_DIM_W-1:0];
        CFG_IDX_HEIGHT:   height_q   <= cfg_wdata_i[CFG_DIM_W-1:0];
        CFG_IDX_SCALE:    scale_q    <= cfg_wdata_i[CFG_SCALE_W-1:0];
        CFG_IDX_MIRROR_X: mirror_x_q <= cfg_wdata_i[0];
        CFG_IDX_MIRROR_Y: mirror_y_q <= cfg_wdata_i[0];
        CFG_IDX_NEGATIVE: negative_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one; a size above the limit saturates. The limit only
  // takes effect when it is below the register range, so it always fits.
  function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CFG_DIM_W-1:0] r;
    if (v == '0) begin
      r = CFG_DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = CFG_DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    cfg_o.width    = clamp_dim(width_q);
    cfg_o.height   = clamp_dim(height_q);
    cfg_o.scale    = (32'(scale_q) > 32'(MAX_SCALE)) ? CFG_SCALE_W'(MAX_SCALE) : scale_q;
    cfg_o.mirror_x = mirror_x_q;
    cfg_o.mirror_y = mirror_y_q;
    cfg_o.negative = negative_q;
  end

endmodule

// File: src/prre_run_core.sv
// Column and row counters, run state and scaled segment coordinates.
module prre_run_core #(
  parameter int unsigned MAX_DIM = prre_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prre_pkg::cfg_t              cfg_i,
  input  logic                        step_i,
  input  logic [prre_pkg::PIX_W-1:0]  pix_i,
  output logic                        emit_o,
  output prre_pkg::seg_t              seg_o
);
  import prre_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIM);
  localparam int unsigned CmpW = ((CntW > CFG_DIM_W) ? CntW : CFG_DIM_W) + 1;
  localparam int unsigned PrdW = CmpW + CFG_SCALE_W;

  logic [CntW-1:0]    col_q, col_d, row_q, row_d;
  logic               run_q, run_d;
  logic [COORD_W-1:0] start_q, start_d;

  logic [CmpW-1:0]    col_ext, row_ext, w_ext, h_ext, x, y;
  logic [PrdW-1:0]    x_prd, y_prd;
  logic [COORD_W-1:0] sx, sy;
  logic [PIX_W-1:0]   fg, bg;
  logic               fg_hit, bg_hit, row_end, run_after, opens;

  always_comb begin
    col_ext = CmpW'(col_q);
    row_ext = CmpW'(row_q);
    w_ext   = CmpW'(cfg_i.width);
    h_ext   = CmpW'(cfg_i.height);

    // Mirrored coordinates are absolute differences, which also covers a
    // counter left beyond a size that was made smaller mid-frame.
    if (cfg_i.mirror_x) begin
      x = (col_ext >= w_ext) ? (col_ext - w_ext) : (w_ext - col_ext);
    end else begin
      x = col_ext;
    end
    if (cfg_i.mirror_y) begin
      y = row_ext;
    end else begin
      y = (row_ext >= h_ext) ? (row_ext - h_ext) : (h_ext - row_ext);
    end

    x_prd = PrdW'(x) * PrdW'(cfg_i.scale);
    y_prd = PrdW'(y) * PrdW'(cfg_i.scale);
    sx    = x_prd[COORD_W-1:0];
    sy    = y_prd[COORD_W-1:0];

    fg     = cfg_i.negative ? COLOR_WHITE : COLOR_BLACK;
    bg     = cfg_i.negative ? COLOR_BLACK : COLOR_WHITE;
    fg_hit = (pix_i == fg);
    bg_hit = (pix_i == bg);

    row_end   = (col_ext + CmpW'(1)) >= w_ext;
    opens     = fg_hit && !run_q;
    run_after = fg_hit ? 1'b1 : (bg_hit ? 1'b0 : run_q);

    // A background pixel closes an open run; a run still open at the row end
    // is flushed, including one opened by the last pixel itself.
    emit_o        = (bg_hit && run_q) || (row_end && run_after);
    seg_o.x_start = opens ? sx : start_q;
    seg_o.y       = sy;
    seg_o.x_end   = sx;

    start_d = opens ? sx : start_q;
    run_d   = row_end ? 1'b0 : run_after;
    if (row_end) begin
      col_d = '0;
      row_d = ((row_ext + CmpW'(1)) >= h_ext) ? '0 : (row_q + CntW'(1));
    end else begin
      col_d = col_q + CntW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      run_q   <= 1'b0;
      start_q <= '0;
    end else if (step_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      run_q   <= run_d;
      start_q <= start_d;
    end
  end

endmodule

// File: src/prre_out_reg.sv
// Result register holding one segment word until the receiver takes it.
module prre_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            emit_i,
  input  prre_pkg::seg_t  seg_i,
  input  logic            out_stall_i,
  output logic            free_o,
  output logic            out_valid_o,
  output prre_pkg::seg_t  seg_o
);
  import prre_pkg::*;

  logic valid_q, valid_d;
  seg_t seg_q;

  // The slot can take a new result when empty or when its word leaves now.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = emit_i;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      seg_q <= seg_i;
    end
  end

  assign out_valid_o = valid_q;
  assign seg_o       = seg_q;

endmodule

// File: src/pixel_row_run_extractor_unit.sv
// Top level of the pixel row run extractor.
//
// Pixels enter as one 24-bit word per handshake on the input channel
// (in_valid_i, in_stall_o, pixel_color_i), row by row in raster order.
// Black pixels (white ones when negative is set) form runs, the other of the
// two closes a run, and any other color leaves the run state alone. Each run
// leaves as one segment word on the output channel (out_valid_o, out_stall_i,
// seg_x_start_o, seg_y_o, seg_x_end_o); a run still open at the last pixel of
// a row is flushed with that pixel's x as its end.
// One pixel is accepted per clock unless the receiver stalls. A segment
// is held first, as its pixel, in the input register and then in the result
// register. Throughput is one pixel per cycle under the same condition, set by
// the single pass through the coordinate multipliers.
// While the receiver stalls a held segment, that word stays put and the run
// state does not advance; the input register takes one more pixel and then
// stalls the source until the segment leaves.
// Reset clears the column and row counters and the run state, empties both
// registers and loads the default geometry of 640 by 480, scale one, both
// mirror flags clear, black foreground. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i while no pixel is in flight.
module pixel_row_run_extractor_unit #(
  parameter int unsigned MAX_DIM   = prre_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_SCALE = prre_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prre_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [prre_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [prre_pkg::PIX_W-1:0]        pixel_color_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [prre_pkg::COORD_W-1:0]      seg_x_start_o,
  output logic [prre_pkg::COORD_W-1:0]      seg_y_o,
  output logic [prre_pkg::COORD_W-1:0]      seg_x_end_o
);
  import prre_pkg::*;

  cfg_t             cfg;
  seg_t             seg_new, seg_out;
  logic             emit, out_free, step, accept;
  logic             in_valid_q, in_valid_d;
  logic [PIX_W-1:0] pix_q;

  prre_cfg_regs #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The buffered pixel is processed as soon as the result register can take
  // whatever it produces; the run state advances in that same cycle.
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_color_i;
    end
  end

  prre_run_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .pix_i  (pix_q),
    .emit_o (emit),
    .seg_o  (seg_new)
  );

  prre_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .emit_i      (emit),
    .seg_i       (seg_new),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .seg_o       (seg_out)
  );

  assign seg_x_start_o = seg_out.x_start;
  assign seg_y_o       = seg_out.y;
  assign seg_x_end_o   = seg_out.x_end;

endmodule

// File: tb/tb_pixel_row_run_extractor_unit.sv
// Self-checking testbench of the pixel row run extractor: predicted segments against the block.
module tb_pixel_row_run_extractor_unit;
  import prre_pkg::*;

  // Tracks the geometry registers and the column, row and run state of the
  // block, and keeps the segments that accepted pixels must still produce.
  class segment_predictor;
    logic [CFG_DIM_W-1:0]   width_reg;
    logic [CFG_DIM_W-1:0]   height_reg;
    logic [CFG_SCALE_W-1:0] scale_reg;
    logic                   mirror_x_reg;
    logic                   mirror_y_reg;
    logic                   negative_reg;
    logic [11:0]            column;
    logic [11:0]            row;
    logic                   run_open;
    logic [COORD_W-1:0]     run_start;
    seg_t                   segments_due[$];
    int unsigned            mismatches;

    function new();
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      scale_reg    = SCALE_RST;
      mirror_x_reg = 1'b0;
      mirror_y_reg = 1'b0;
      negative_reg = 1'b0;
      column       = '0;
      row          = '0;
      run_open     = 1'b0;
      run_start    = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_WIDTH:    width_reg = data;
        CFG_IDX_HEIGHT:   height_reg = data;
        CFG_IDX_SCALE:    scale_reg = data[CFG_SCALE_W-1:0];
        CFG_IDX_MIRROR_X: mirror_x_reg = data[0];
        CFG_IDX_MIRROR_Y: mirror_y_reg = data[0];
        CFG_IDX_NEGATIVE: negative_reg = data[0];
        default: ;
      endcase
    endfunction

    // A size of zero counts as one, and anything beyond the maximum saturates.
    function int unsigned dim_eff(logic [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    // A mirrored position is its distance to the size, which stays sane even
    // when the counter has run past a size that shrank mid-frame.
    function int unsigned coord(int unsigned pos, int unsigned size, logic mirror);
      int unsigned p;
      if (mirror) p = (pos >= size) ? pos - size : size - pos;
      else p = pos;
      return (p * scale_reg) & 32'h000f_ffff;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned        w;
      int unsigned        h;
      int unsigned        sx;
      int unsigned        sy;
      logic [PIX_W-1:0]   fg;
      logic [PIX_W-1:0]   bg;
      seg_t               seg;
      w  = dim_eff(width_reg);
      h  = dim_eff(height_reg);
      fg = negative_reg ? COLOR_WHITE : COLOR_BLACK;
      bg = negative_reg ? COLOR_BLACK : COLOR_WHITE;
      sx = coord(column, w, mirror_x_reg);
      // The y axis counts from the bottom unless mirror_y is set.
      sy = coord(row, h, !mirror_y_reg);
      seg.x_start = run_start;
      seg.y       = sy[COORD_W-1:0];
      seg.x_end   = sx[COORD_W-1:0];
      if (pix == fg) begin
        if (!run_open) begin
          run_start   = sx[COORD_W-1:0];
          seg.x_start = run_start;
          run_open    = 1'b1;
        end
      end else if (pix == bg) begin
        if (run_open) segments_due.push_back(seg);
        run_open = 1'b0;
      end
      // The last pixel of a row flushes any run still open, with its own x.
      if (column + 1 >= w) begin
        if (run_open) segments_due.push_back(seg);
        run_open = 1'b0;
        column   = '0;
        if (row + 1 >= h) row = '0;
        else row = row + 1;
      end else begin
        column = column + 1;
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (segments_due.size() == 0) begin
        $display("%0t: segment with none due: x_start %0d y %0d x_end %0d",
                 $time, got.x_start, got.y, got.x_end);
        mismatches++;
        return;
      end
      want = segments_due.pop_front();
      if (got.x_start !== want.x_start) begin
        $display("%0t: x_start expected %0d actual %0d", $time, want.x_start, got.x_start);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $display("%0t: y expected %0d actual %0d", $time, want.y, got.y);
        mismatches++;
      end
      if (got.x_end !== want.x_end) begin
        $display("%0t: x_end expected %0d actual %0d", $time, want.x_end, got.x_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_color_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [COORD_W-1:0]    seg_x_start_o;
  logic [COORD_W-1:0]    seg_y_o;
  logic [COORD_W-1:0]    seg_x_end_o;

  // When set, neither the pixel source nor the segment sink holds back.
  bit steady;

  segment_predictor predictor = new();

  pixel_row_run_extractor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_color_i (pixel_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seg_x_start_o (seg_x_start_o),
    .seg_y_o       (seg_y_o),
    .seg_x_end_o   (seg_x_end_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Both channels are sampled at the rising edge. A pixel can never produce
  // its segment in the cycle it is taken, so the order of the two is free.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predictor.note_pixel(pixel_color_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      predictor.check_segment('{x_start: seg_x_start_o, y: seg_y_o, x_end: seg_x_end_o});
    end
  end

  // The sink stalls at random, 35 times in 100, except in steady stretches.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 35);
  end

  // Mostly black and white so that runs form, with some arbitrary colors and
  // some that miss black or white by a single bit.
  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return COLOR_BLACK;
    if (roll < 80) return COLOR_WHITE;
    if (roll < 90) return PIX_W'($urandom);
    return ($urandom_range(0, 1) ? COLOR_WHITE : COLOR_BLACK) ^ (24'd1 << $urandom_range(0, 23));
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while (!steady && $urandom_range(0, 99) < 35) begin
      in_valid_i    <= 1'b0;
      pixel_color_i <= PIX_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_color_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Waits until every predicted segment has come out, then gives pixels that
  // yield nothing time to leave both pipeline registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predictor.segments_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all six registers back to back; the unused upper data bits of the
  // narrow registers carry junk, which the block must ignore.
  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned s,
                           input bit mx, input bit my, input bit neg);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_IDX_WIDTH, CFG_IDX_HEIGHT, CFG_IDX_SCALE,
            CFG_IDX_MIRROR_X, CFG_IDX_MIRROR_Y, CFG_IDX_NEGATIVE};
    val = '{CFG_DATA_W'(w), CFG_DATA_W'(h), {5'($urandom), 8'(s)},
            {12'($urandom), mx}, {12'($urandom), my}, {12'($urandom), neg}};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      predictor.write_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
                           input bit mx, input bit my, input bit neg,
                           input int unsigned count, input bit quiet);
    drain();
    configure(w, h, s, mx, my, neg);
    steady = quiet;
    repeat (count) send_pixel(pick_pixel());
    steady = 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0] opening [9];
    logic [PIX_W-1:0] row_edges [13];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_IDX_WIDTH;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    pixel_color_i = '0;
    out_stall_i   = 1'b0;
    steady        = 1'b0;
    // Default geometry: a run closed by white, colors one bit away from black
    // and white that must leave the run alone, and white with no run open.
    opening = '{COLOR_BLACK, COLOR_BLACK, COLOR_WHITE, 24'h000001, COLOR_WHITE,
                24'hfffffe, COLOR_BLACK, 24'h123456, COLOR_WHITE};
    // Rows of four. The first pixel lands past the shrunk width and ends its
    // row at once while opening a run, so start equals end. Then a run
    // flushed at row end, a run closed by the last pixel of its row, and a
    // run that opens on the last pixel.
    row_edges = '{COLOR_BLACK,
                  COLOR_BLACK, COLOR_BLACK, COLOR_BLACK, COLOR_BLACK,
                  COLOR_WHITE, COLOR_BLACK, COLOR_BLACK, COLOR_WHITE,
                  COLOR_WHITE, COLOR_WHITE, COLOR_WHITE, COLOR_BLACK};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (opening[i]) send_pixel(opening[i]);
    drain();
    configure(4, 2, 255, 1'b1, 1'b1, 1'b0);
    foreach (row_edges[i]) send_pixel(row_edges[i]);

    run_phase(8, 3, 1, 1'b0, 1'b0, 1'b0, 150, 1'b0);
    run_phase(1, 1, 255, 1'b1, 1'b0, 1'b1, 80, 1'b0);
    run_phase(0, 0, 7, 1'b0, 1'b1, 1'b0, 80, 1'b0);
    run_phase(8191, 8191, 255, 1'b1, 1'b0, 1'b0, 100, 1'b0);
    run_phase(4096, 4096, 0, 1'b0, 1'b0, 1'b1, 60, 1'b0);
    run_phase(16, 5, 3, 1'b1, 1'b1, 1'b1, 200, 1'b1);
    run_phase(5, 2, 128, 1'b0, 1'b0, 1'b0, 120, 1'b0);
    run_phase(12, 4096, 17, 1'b1, 1'b0, 1'b0, 100, 1'b0);
    repeat (3) begin
      run_phase($urandom_range(0, 24), $urandom_range(0, 9), $urandom_range(0, 255),
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), 40, 1'b0);
    end
    drain();
    repeat (8) @(negedge clk_i);

    if (predictor.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
